[hw/rtl/frame_bitmap_allocator_unit_assert.svh]
// assertion macros for the frame bitmap allocator
// used by fba_back, the one module of hw/rtl that checks its own logic
`ifndef FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define FBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fba assertion failed");
`define FBA_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("fba forbidden condition");
`else
`define FBA_ASSERT(lbl, clk, rstn, prop)
`define FBA_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[hw/rtl/fba_pkg.sv]
// shared constants and types of the frame bitmap allocator
// no dependencies
package fba_pkg;

  localparam int FRAMES_DEF      = 131072;
  localparam int FRAME_BYTES_DEF = 4096;
  localparam int ADDR_W          = 64;
  localparam int KIND_W          = 3;
  localparam int FADDR_W         = 29;
  localparam int OP_W            = 3;

  // request kinds on the input channel
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MARK    = 3'd4;

  // classified operations passed to the back end
  localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
  localparam logic [OP_W-1:0] OP_SET   = 3'd2;
  localparam logic [OP_W-1:0] OP_CLR   = 3'd3;
  localparam logic [OP_W-1:0] OP_MARK  = 3'd4;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

[hw/rtl/frame_bitmap_allocator_unit.sv]
// top level of the frame bitmap allocator
// depends on fba_pkg, fba_front, fba_queue and fba_back
//
// first-fit page frame allocator over a used/free bitmap, one bit per frame
// input channel: in_tuser carries the request kind, in_tdata the byte range
// result channel: exactly one transfer per request, in request order
// after reset a clearing pass marks every frame used;
// in_tready stays low during it
// a request waits in the queue, then the back end walks bitmap words
// through one memory port, reading each word in S_RD and updating it in S_MOD:
//   free, one-word ranges and allocate hitting the first word: one word
//   ranges: every word touched
//   allocate: words scanned from the lowest word that may be free
//   mark-all: every word, rewritten by the clearing pass
// a two-entry queue lets the front end take requests while the back end works
// a finished result sits in the output register; a stalled receiver holds the
// back end once that register is full, and in_tready drops once the queue fills
module frame_bitmap_allocator_unit #(
  parameter int FRAMES      = fba_pkg::FRAMES_DEF,
  parameter int FRAME_BYTES = fba_pkg::FRAME_BYTES_DEF  // power of two
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // start_addr [63:0], end_addr [127:64]
  input  logic [2:0]   in_tuser,   // kind [2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // page address [28:0], zero fill [31:29]
  output logic [0:0]   out_tuser   // none_free [0]
);

  localparam int FW = $clog2(FRAMES + 1);
  localparam int QW = fba_pkg::OP_W + 2 * FW;

  logic [fba_pkg::OP_W-1:0]    f_op;
  logic [FW-1:0]               f_lo;
  logic [FW-1:0]               f_hi;
  logic                        push_ready;
  logic                        pop_valid;
  logic                        pop_ready;
  logic [QW-1:0]               pop_data;
  logic [fba_pkg::FADDR_W-1:0] res_addr;
  logic                        res_none;
  fba_pkg::back_stat_t         stat;

  // classify each request as it arrives
  fba_front #(
    .FRAMES      (FRAMES),
    .FRAME_BYTES (FRAME_BYTES),
    .FW          (FW)
  ) u_front (
    .kind       (in_tuser),
    .start_addr (in_tdata[63:0]),
    .end_addr   (in_tdata[127:64]),
    .op         (f_op),
    .lo         (f_lo),
    .hi         (f_hi)
  );

  // no transfer is taken during the clearing pass after reset
  assign in_tready = push_ready & ~stat.init_busy;

  fba_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid & ~stat.init_busy),
    .push_ready (push_ready),
    .push_data  ({f_op, f_lo, f_hi}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  fba_back #(
    .FRAMES      (FRAMES),
    .FRAME_BYTES (FRAME_BYTES),
    .FW          (FW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_op      (pop_data[QW-1 -: fba_pkg::OP_W]),
    .q_lo      (pop_data[2*FW-1 -: FW]),
    .q_hi      (pop_data[FW-1:0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (res_addr),
    .out_none  (res_none),
    .stat      (stat)
  );

  assign out_tdata = {3'b000, res_addr};
  assign out_tuser = res_none;

endmodule

[hw/rtl/fba_front.sv]
// front end: turns a request into an operation on a frame range
// depends on fba_pkg
module fba_front #(
  parameter int FRAMES      = fba_pkg::FRAMES_DEF,
  parameter int FRAME_BYTES = fba_pkg::FRAME_BYTES_DEF,
  parameter int FW          = $clog2(FRAMES + 1)
) (
  input  logic [fba_pkg::KIND_W-1:0] kind,
  input  logic [fba_pkg::ADDR_W-1:0] start_addr,
  input  logic [fba_pkg::ADDR_W-1:0] end_addr,
  output logic [fba_pkg::OP_W-1:0]   op,
  output logic [FW-1:0]              lo,
  output logic [FW-1:0]              hi
);

  localparam int FB_SHIFT = $clog2(FRAME_BYTES);
  localparam logic [63:0] LIMIT = 64'(FRAMES) << FB_SHIFT;

  logic [63:0] end_c;
  logic [63:0] s_fl;
  logic [63:0] s_cl;
  logic [63:0] e_fl;
  logic [63:0] e_cl;

  always_comb begin
    end_c = (end_addr > LIMIT) ? LIMIT : end_addr;
    s_fl  = start_addr >> FB_SHIFT;
    s_cl  = s_fl + 64'(|start_addr[FB_SHIFT-1:0]);
    e_fl  = end_c >> FB_SHIFT;
    e_cl  = e_fl + 64'(|end_c[FB_SHIFT-1:0]);
    op    = fba_pkg::OP_NOP;
    lo    = '0;
    hi    = '0;
    case (kind)
      fba_pkg::KIND_ALLOC: begin
        op = fba_pkg::OP_ALLOC;
      end
      fba_pkg::KIND_FREE: begin
        if (s_fl < 64'(FRAMES)) begin
          op = fba_pkg::OP_CLR;
          lo = FW'(s_fl);
          hi = FW'(s_fl + 64'd1);
        end
      end
      fba_pkg::KIND_RESERVE: begin
        if (start_addr < LIMIT && start_addr < end_c) begin
          op = fba_pkg::OP_SET;
          lo = FW'(s_fl);
          hi = FW'(e_cl);
        end
      end
      fba_pkg::KIND_RELEASE: begin
        // rounded inward, may leave no whole frame
        if (start_addr < end_c && s_cl < e_fl) begin
          op = fba_pkg::OP_CLR;
          lo = FW'(s_cl);
          hi = FW'(e_fl);
        end
      end
      fba_pkg::KIND_MARK: begin
        op = fba_pkg::OP_MARK;
      end
      default: begin
        op = fba_pkg::OP_NOP;
      end
    endcase
  end

endmodule

[hw/rtl/fba_queue.sv]
// two-entry queue between front and back end
// depends on nothing but its width parameter
module fba_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wp_r;
  logic         wp_nxt;
  logic         rp_r;
  logic         rp_nxt;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rp_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

[hw/rtl/fba_back.sv]
// back end: bitmap memory, word walker, free search and result register
// depends on fba_pkg and frame_bitmap_allocator_unit_assert.svh
`include "frame_bitmap_allocator_unit_assert.svh"
module fba_back #(
  parameter int FRAMES      = fba_pkg::FRAMES_DEF,
  parameter int FRAME_BYTES = fba_pkg::FRAME_BYTES_DEF,
  parameter int FW          = $clog2(FRAMES + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  logic [fba_pkg::OP_W-1:0]     q_op,
  input  logic [FW-1:0]                q_lo,
  input  logic [FW-1:0]                q_hi,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fba_pkg::FADDR_W-1:0]  out_addr,
  output logic                         out_none,
  output fba_pkg::back_stat_t          stat
);

  localparam int FB_SHIFT = $clog2(FRAME_BYTES);
  localparam int WORDS    = (FRAMES + 63) / 64;
  localparam int WIDX_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int WHINT_W  = $clog2(WORDS + 1);
  localparam int WC_W     = FW - 6;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [63:0] mem [WORDS];
  logic [63:0] rdata_r;
  logic        mem_we;
  logic [63:0] mem_wdata;

  logic [2:0]                  state_r, state_nxt;
  logic [fba_pkg::OP_W-1:0]    op_r, op_nxt;
  logic [WC_W-1:0]             cur_r, cur_nxt;
  logic [FW-1:0]               lo_r, lo_nxt;
  logic [FW-1:0]               last_r, last_nxt;
  logic [WHINT_W-1:0]          hint_r, hint_nxt;
  logic [fba_pkg::FADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic                        res_none_r, res_none_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [fba_pkg::FADDR_W-1:0] out_addr_r;
  logic                        out_none_r;
  logic                        load_out;

  logic [63:0] free_bits;
  logic [5:0]  pe_bit;
  logic [5:0]  lo_b;
  logic [5:0]  hi_b;
  logic [63:0] mask;
  logic [63:0] faddr;
  logic        at_last_word;

  always_comb begin
    pe_bit    = 6'd0;
    free_bits = ~rdata_r;
    for (int i = 63; i >= 0; i--) begin
      if (free_bits[i]) begin
        pe_bit = 6'(i);
      end
    end
    lo_b  = (cur_r == lo_r[FW-1:6]) ? lo_r[5:0] : 6'd0;
    hi_b  = (cur_r == last_r[FW-1:6]) ? last_r[5:0] : 6'd63;
    mask  = ({64{1'b1}} << lo_b) & ({64{1'b1}} >> (6'd63 - hi_b));
    faddr = 64'({cur_r, pe_bit}) << FB_SHIFT;
    at_last_word = (cur_r == WC_W'(WORDS - 1));
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    cur_nxt      = cur_r;
    lo_nxt       = lo_r;
    last_nxt     = last_r;
    hint_nxt     = hint_r;
    res_addr_nxt = res_addr_r;
    res_none_nxt = res_none_r;
    mem_we       = 1'b0;
    mem_wdata    = {64{1'b1}};
    q_ready      = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (at_last_word) begin
          hint_nxt     = WHINT_W'(WORDS);
          res_addr_nxt = '0;
          res_none_nxt = 1'b0;
          state_nxt    = (op_r == fba_pkg::OP_MARK) ? S_OUT : S_IDLE;
        end else begin
          cur_nxt = cur_r + WC_W'(1);
        end
      end
      S_IDLE: begin
        q_ready      = 1'b1;
        res_addr_nxt = '0;
        res_none_nxt = 1'b0;
        if (q_valid) begin
          op_nxt = q_op;
          case (q_op)
            fba_pkg::OP_ALLOC: begin
              if (hint_r == WHINT_W'(WORDS)) begin
                res_none_nxt = 1'b1;
                state_nxt    = S_OUT;
              end else begin
                cur_nxt   = WC_W'(hint_r);
                state_nxt = S_RD;
              end
            end
            fba_pkg::OP_SET, fba_pkg::OP_CLR: begin
              cur_nxt   = q_lo[FW-1:6];
              lo_nxt    = q_lo;
              last_nxt  = q_hi - FW'(1);
              state_nxt = S_RD;
            end
            fba_pkg::OP_MARK: begin
              cur_nxt   = '0;
              state_nxt = S_CLR;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (op_r == fba_pkg::OP_ALLOC) begin
          if (free_bits != 64'd0) begin
            mem_we       = 1'b1;
            mem_wdata    = rdata_r | (64'd1 << pe_bit);
            res_addr_nxt = faddr[fba_pkg::FADDR_W-1:0];
            state_nxt    = S_OUT;
          end else if (at_last_word) begin
            hint_nxt     = WHINT_W'(WORDS);
            res_none_nxt = 1'b1;
            state_nxt    = S_OUT;
          end else begin
            cur_nxt   = cur_r + WC_W'(1);
            hint_nxt  = WHINT_W'(cur_r + WC_W'(1));
            state_nxt = S_RD;
          end
        end else begin
          mem_we = 1'b1;
          if (op_r == fba_pkg::OP_SET) begin
            mem_wdata = rdata_r | mask;
          end else begin
            mem_wdata = rdata_r & ~mask;
            if (WHINT_W'(cur_r) < hint_r) begin
              hint_nxt = WHINT_W'(cur_r);
            end
          end
          if (cur_r == last_r[FW-1:6]) begin
            state_nxt = S_OUT;
          end else begin
            cur_nxt   = cur_r + WC_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = load_out | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      op_r        <= fba_pkg::OP_NOP;
      cur_r       <= '0;
      hint_r      <= WHINT_W'(WORDS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      cur_r       <= cur_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    last_r     <= last_nxt;
    res_addr_r <= res_addr_nxt;
    res_none_r <= res_none_nxt;
    if (load_out) begin
      out_addr_r <= res_addr_r;
      out_none_r <= res_none_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_r[WIDX_W-1:0]] <= mem_wdata;
    end
    rdata_r <= mem[cur_r[WIDX_W-1:0]];
  end

  assign out_valid      = out_valid_r;
  assign out_addr       = out_addr_r;
  assign out_none       = out_none_r;
  assign stat.init_busy = (state_r == S_CLR) && (op_r != fba_pkg::OP_MARK);

  `FBA_NEVER(a_no_wr_idle, clk, rst_n, state_r == S_IDLE && mem_we)
  `FBA_NEVER(a_hint_range, clk, rst_n, hint_r > WHINT_W'(WORDS))
  `FBA_ASSERT(a_sweep_full, clk, rst_n, (state_r == S_CLR && at_last_word) |=> hint_r == WHINT_W'(WORDS))
  `FBA_ASSERT(a_empty_zero, clk, rst_n, (out_valid_r && out_none_r) |-> out_addr_r == '0)

endmodule

[test/frame_bitmap_allocator_unit_chk.sv]
// result checker for the frame bitmap allocator: mirrors the used/free map,
// predicts one result per accepted request and compares; depends on fba_pkg
module frame_bitmap_allocator_unit_chk #(
  parameter int FRAMES      = fba_pkg::FRAMES_DEF,
  parameter int FRAME_BYTES = fba_pkg::FRAME_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  input  logic [0:0]   out_tuser,
  output int           fail_count,
  output int           results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_WORDS = (FRAMES + 63) / 64;
  localparam longint unsigned MEM_LIMIT = longint'(FRAMES) * longint'(FRAME_BYTES);

  typedef struct packed {
    logic [31:0] page_addr;
    logic        none_free;
  } alloc_result_t;

  logic [63:0]   frame_map [MAP_WORDS];
  alloc_result_t result_fifo [$];
  int            fails = 0;
  int            pending = 0;

  function automatic void mark_frames(longint unsigned lo, longint unsigned hi, logic used);
    for (longint unsigned f = lo; f < hi; f++) frame_map[f >> 6][f & 63] = used;
  endfunction

  function automatic alloc_result_t serve_request(logic [2:0] kind,
                                                  longint unsigned start_a,
                                                  longint unsigned end_a);
    alloc_result_t r;
    longint unsigned fb;
    r = '0;
    fb = FRAME_BYTES;
    case (kind)
      fba_pkg::KIND_ALLOC: begin
        r.none_free = 1'b1;
        for (int w = 0; w < MAP_WORDS && r.none_free; w++) begin
          if (frame_map[w] != '1) begin
            for (int b = 0; b < 64 && r.none_free; b++) begin
              if (!frame_map[w][b] && (w * 64 + b) < FRAMES) begin
                frame_map[w][b] = 1'b1;
                r.page_addr = 32'((longint'(w * 64 + b) * fb) & 64'h1FFF_FFFF);
                r.none_free = 1'b0;
              end
            end
          end
        end
      end
      fba_pkg::KIND_FREE: begin
        if (start_a / fb < FRAMES) mark_frames(start_a / fb, start_a / fb + 1, 1'b0);
      end
      fba_pkg::KIND_RESERVE: begin
        if (start_a < MEM_LIMIT) begin
          if (end_a > MEM_LIMIT) end_a = MEM_LIMIT;
          if (start_a < end_a) mark_frames(start_a / fb, (end_a + fb - 1) / fb, 1'b1);
        end
      end
      fba_pkg::KIND_RELEASE: begin
        if (end_a > MEM_LIMIT) end_a = MEM_LIMIT;
        if (start_a < end_a) mark_frames((start_a + fb - 1) / fb, end_a / fb, 1'b0);
      end
      fba_pkg::KIND_MARK: begin
        for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = '1;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign fail_count  = fails;
  assign results_due = pending;

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      for (int w = 0; w < MAP_WORDS; w++) frame_map[w] = '1;
      result_fifo.delete();
    end else begin
      if (in_tvalid && in_tready)
        result_fifo.push_back(serve_request(in_tuser, in_tdata[63:0], in_tdata[127:64]));
      if (out_tvalid && out_tready) begin
        if (result_fifo.size() == 0) begin
          fails++;
          $display("%t: unexpected result addr=%h none_free=%b", $time, out_tdata, out_tuser);
        end else begin
          want = result_fifo.pop_front();
          if (out_tdata !== want.page_addr || out_tuser[0] !== want.none_free) begin
            fails++;
            $display("%t: mismatch expected addr=%h none_free=%b, actual addr=%h none_free=%b",
                     $time, want.page_addr, want.none_free, out_tdata, out_tuser);
          end
        end
      end
    end
    pending = result_fifo.size();
  end
endmodule

[test/frame_bitmap_allocator_unit_tb.sv]
// testbench top for the frame bitmap allocator: drives requests, stalls the
// result side and gives the verdict; depends on fba_pkg, the design top and the checker module
module frame_bitmap_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned FB        = fba_pkg::FRAME_BYTES_DEF;
  localparam longint unsigned MEM_LIMIT = longint'(fba_pkg::FRAMES_DEF) * FB;
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;   // kinds 5..7 do nothing
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;     // start_addr [63:0], end_addr [127:64]
  logic [2:0]   in_tuser = '0;     // kind [2:0]
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;         // page address [28:0], zero fill [31:29]
  logic [0:0]   out_tuser;         // none_free [0]

  int fail_count, results_due;
  int burst_left = 0;
  int kind_seen [8];
  bit hold_off_req = 1'b0;         // asks the receiver for one long stall
  bit hold_off_done = 1'b0;

  always #6 clk = ~clk;

  frame_bitmap_allocator_unit dut (.*);
  frame_bitmap_allocator_unit_chk chk (.*);

  // one request transfer; valid stays up inside a burst, drops in the gaps
  task automatic send_request(logic [2:0] kind, longint unsigned start_a,
                              longint unsigned end_a);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {end_a, start_a};
    do @(posedge clk); while (!in_tready);
    kind_seen[kind]++;
  endtask

  // address mostly inside a small low window, now and then just below the top or anywhere at all
  function automatic longint unsigned pick_addr();
    if ($urandom_range(0, 19) == 0) return {$urandom, $urandom};
    if ($urandom_range(0, 29) == 0) return MEM_LIMIT - 64'($urandom_range(0, 300000));
    return 64'($urandom_range(0, 600 * 4096));
  endfunction

  // receiver: random stall pattern, quiet stretches, one long hold-off
  initial begin
    int hold;
    int mode_left;
    int mode;
    mode_left = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_tready <= 1'b0;
        for (hold = 0; hold < 500; hold++) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: out_tready <= 1'b1;                                // no stalls
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // hard stop in case the block hangs
  initial begin
    #600ms;
    $display("%t: timeout with %0d results outstanding", $time, results_due);
    $display("** frame_bitmap_allocator_unit: FAILED **");
    $finish;
  end

  initial begin
    int pick;
    int spare_seen;
    longint unsigned s, e;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty map, frame zero, rounding, clipping, ends of the fields
    send_request(fba_pkg::KIND_ALLOC, 0, 0);                 // every frame used
    send_request(fba_pkg::KIND_RELEASE, 0, 64 * FB);
    send_request(fba_pkg::KIND_ALLOC, '1, '1);               // frame zero
    send_request(fba_pkg::KIND_ALLOC, 0, 0);
    send_request(fba_pkg::KIND_FREE, 100, 0);                // frees frame zero
    send_request(fba_pkg::KIND_FREE, MEM_LIMIT, 0);          // past the end
    send_request(fba_pkg::KIND_FREE, '1, '1);
    send_request(fba_pkg::KIND_RESERVE, FB + 1, 3 * FB - 1); // rounded outward
    send_request(fba_pkg::KIND_RELEASE, FB + 1, 4 * FB - 1); // rounded inward
    send_request(fba_pkg::KIND_RESERVE, MEM_LIMIT, '1);      // start at limit
    send_request(fba_pkg::KIND_RESERVE, 8 * FB, 8 * FB);     // empty range
    send_request(fba_pkg::KIND_RELEASE, 9 * FB, 2 * FB);     // reversed range
    send_request(fba_pkg::KIND_ALLOC, 0, 0);
    send_request(fba_pkg::KIND_MARK, 0, 0);
    send_request(fba_pkg::KIND_RELEASE, MEM_LIMIT - 2 * FB, '1);  // clipped at top
    send_request(fba_pkg::KIND_ALLOC, 0, 0);                 // widest address
    send_request(fba_pkg::KIND_ALLOC, 0, 0);
    send_request(fba_pkg::KIND_ALLOC, 0, 0);                 // empty again
    send_request(fba_pkg::KIND_RELEASE, 0, '1);              // whole map free
    send_request(fba_pkg::KIND_RESERVE, 0, MEM_LIMIT + 5);
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      send_request(3'(k), '1, '1);
    send_request(fba_pkg::KIND_RELEASE, 0, 256 * FB);

    // random part; the long receiver hold-off lands early in it
    hold_off_req = 1'b1;
    for (int n = 0; n < 2000; n++) begin
      pick = $urandom_range(0, 99);
      s = pick_addr();
      e = ($urandom_range(0, 9) == 0) ? pick_addr() : s + 64'($urandom_range(0, 40000));
      if (pick < 32)      send_request(fba_pkg::KIND_ALLOC, s, e);
      else if (pick < 52) send_request(fba_pkg::KIND_FREE, s, e);
      else if (pick < 68) send_request(fba_pkg::KIND_RESERVE, s, e);
      else if (pick < 94) send_request(fba_pkg::KIND_RELEASE, s, e);
      else if (pick < 95) send_request(fba_pkg::KIND_MARK, s, e);
      else if (pick < 98) send_request(3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)), s, e);
      else if (pick < 99) send_request(fba_pkg::KIND_RELEASE, 64'($urandom_range(0, 4096)), '1);
      else                send_request(fba_pkg::KIND_RESERVE, s, '1);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    spare_seen = 0;
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++) spare_seen += kind_seen[k];
    $display("covered %0d allocate, %0d free, %0d reserve, %0d release, %0d mark-all",
             kind_seen[fba_pkg::KIND_ALLOC], kind_seen[fba_pkg::KIND_FREE],
             kind_seen[fba_pkg::KIND_RESERVE], kind_seen[fba_pkg::KIND_RELEASE],
             kind_seen[fba_pkg::KIND_MARK]);
    $display("and %0d unknown-kind requests, under random stalls on both sides",
             spare_seen);
    if (fail_count == 0) begin
      $display("** frame_bitmap_allocator_unit: PASSED **");
    end else begin
      $display("** frame_bitmap_allocator_unit: FAILED **");
    end
    $finish;
  end
endmodule
